### hdl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, field widths, codes and parameter defaults of the bilinear
// RGB sampler.
// ----------------------------------------------------------------------------
package bsr_pkg;

	// fixed field widths
	localparam int COORD_BITS  = 16;
	localparam int IN_CH_BITS  = 8;
	localparam int OUT_CH_BITS = 8;
	localparam int CFG_BITS    = 9;

	// parameter defaults
	localparam int MAX_PIXELS_DEF   = 65536;
	localparam int FRAC_BITS_DEF    = 8;
	localparam int CHANNEL_BITS_DEF = 8;

	// register reset values
	localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RST  = 9'd256;
	localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RST = 9'd256;

	// item command codes
	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	// configuration register indexes
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	// one input item
	typedef struct packed {
		logic                  cmd;
		logic [COORD_BITS-1:0] x_pos;
		logic [COORD_BITS-1:0] y_pos;
		logic [IN_CH_BITS-1:0] red_in;
		logic [IN_CH_BITS-1:0] green_in;
		logic [IN_CH_BITS-1:0] blue_in;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [OUT_CH_BITS-1:0] red_out;
		logic [OUT_CH_BITS-1:0] green_out;
		logic [OUT_CH_BITS-1:0] blue_out;
		logic                   out_of_range;
	} out_item_t;

	// per-item control that travels down the pipeline
	typedef struct packed {
		logic valid;
		logic sample;
		logic wr;
		logic oor;
	} pipe_ctrl_t;

endpackage

### hdl/bsr_addr.sv
// ----------------------------------------------------------------------------
// bsr_addr
// Address generation, stages 1 and 2: row * width product, linear address
// of the 2x2 neighbourhood, range checks for writes and samples.
// ----------------------------------------------------------------------------
module bsr_addr
	import bsr_pkg::*;
#(
	parameter int MAX_PIXELS   = MAX_PIXELS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	localparam int ADDR_BITS   = $clog2(MAX_PIXELS),
	localparam int PIX_BITS    = 3 * CHANNEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  in_item_t              item,
	input  logic [CFG_BITS-1:0]   image_width,
	input  logic [CFG_BITS-1:0]   image_height,
	output pipe_ctrl_t            ctrl_s2,
	output logic [ADDR_BITS-1:0]  addr_tl_s2,
	output logic [ADDR_BITS-1:0]  addr_tr_s2,
	output logic [ADDR_BITS-1:0]  addr_bl_s2,
	output logic [ADDR_BITS-1:0]  addr_br_s2,
	output logic [FRAC_BITS-1:0]  fx_s2,
	output logic [FRAC_BITS-1:0]  fy_s2,
	output logic [PIX_BITS-1:0]   pix_s2
);

	// integer part keeps one spare bit so it never has zero width
	localparam int INT_BITS  = COORD_BITS - FRAC_BITS + 1;
	localparam int PROD_BITS = INT_BITS + CFG_BITS;
	localparam int SUM_BITS  = ((PROD_BITS + 2) > (ADDR_BITS + 1)) ?
		(PROD_BITS + 2) : (ADDR_BITS + 1);
	localparam logic [SUM_BITS-1:0] MAX_ADDR = SUM_BITS'(MAX_PIXELS);

	logic [INT_BITS-1:0]  col_in, row_in;
	logic [SUM_BITS-1:0]  col_ext, row_ext, width_ext, height_ext;

	logic                 valid_s1, cmd_s1;
	logic                 col_hi_s1, row_hi_s1, wr_ok_s1;
	logic [INT_BITS-1:0]  col_s1;
	logic [PROD_BITS-1:0] prod_s1;
	logic [FRAC_BITS-1:0] fx_s1, fy_s1;
	logic [PIX_BITS-1:0]  pix_s1;

	logic [SUM_BITS-1:0]  addr_a, addr_a1, addr_b, addr_b1;
	logic                 a_fits, br_fits;

	// split coordinates and widen for compares
	assign col_in     = INT_BITS'(item.x_pos >> FRAC_BITS);
	assign row_in     = INT_BITS'(item.y_pos >> FRAC_BITS);
	assign col_ext    = SUM_BITS'(col_in);
	assign row_ext    = SUM_BITS'(row_in);
	assign width_ext  = SUM_BITS'(image_width);
	assign height_ext = SUM_BITS'(image_height);

	// stage 1: row * width, edge checks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1    <= item.cmd;
		col_s1    <= col_in;
		prod_s1   <= PROD_BITS'(row_in) * PROD_BITS'(image_width);
		fx_s1     <= item.x_pos[FRAC_BITS-1:0];
		fy_s1     <= item.y_pos[FRAC_BITS-1:0];
		pix_s1    <= {CHANNEL_BITS'(item.red_in), CHANNEL_BITS'(item.green_in),
			CHANNEL_BITS'(item.blue_in)};
		col_hi_s1 <= (col_ext + SUM_BITS'(1)) >= width_ext;
		row_hi_s1 <= (row_ext + SUM_BITS'(1)) >= height_ext;
		wr_ok_s1  <= (col_ext < width_ext) && (row_ext < height_ext);
	end

	// linear addresses of the four neighbours
	assign addr_a  = SUM_BITS'(prod_s1) + SUM_BITS'(col_s1);
	assign addr_a1 = addr_a + SUM_BITS'(1);
	assign addr_b  = addr_a + width_ext;
	assign addr_b1 = addr_b + SUM_BITS'(1);
	assign a_fits  = addr_a < MAX_ADDR;
	assign br_fits = addr_b1 < MAX_ADDR;

	// stage 2: final range decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2.valid  <= valid_s1;
			ctrl_s2.sample <= valid_s1 && (cmd_s1 == CMD_SAMPLE);
			ctrl_s2.wr     <= valid_s1 && (cmd_s1 == CMD_WRITE) && wr_ok_s1 && a_fits;
			ctrl_s2.oor    <= col_hi_s1 || row_hi_s1 || !br_fits;
		end
	end

	always_ff @(posedge clk) begin
		addr_tl_s2 <= addr_a[ADDR_BITS-1:0];
		addr_tr_s2 <= addr_a1[ADDR_BITS-1:0];
		addr_bl_s2 <= addr_b[ADDR_BITS-1:0];
		addr_br_s2 <= addr_b1[ADDR_BITS-1:0];
		fx_s2      <= fx_s1;
		fy_s2      <= fy_s1;
		pix_s2     <= pix_s1;
	end

endmodule

### hdl/bsr_mem.sv
// ----------------------------------------------------------------------------
// bsr_mem
// Pixel store: two copies, each with one write port and two read ports.
// The top copy serves the upper pixel pair, the bottom copy the lower pair.
// ----------------------------------------------------------------------------
module bsr_mem
	import bsr_pkg::*;
#(
	parameter int MAX_PIXELS   = MAX_PIXELS_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	localparam int ADDR_BITS   = $clog2(MAX_PIXELS),
	localparam int PIX_BITS    = 3 * CHANNEL_BITS
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [PIX_BITS-1:0]  wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] addr_tl,
	input  logic [ADDR_BITS-1:0] addr_tr,
	input  logic [ADDR_BITS-1:0] addr_bl,
	input  logic [ADDR_BITS-1:0] addr_br,
	output logic [PIX_BITS-1:0]  pix_tl_s3,
	output logic [PIX_BITS-1:0]  pix_tr_s3,
	output logic [PIX_BITS-1:0]  pix_bl_s3,
	output logic [PIX_BITS-1:0]  pix_br_s3
);

	logic [PIX_BITS-1:0] mem_top [MAX_PIXELS];
	logic [PIX_BITS-1:0] mem_bot [MAX_PIXELS];

	// top copy
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_top[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			pix_tl_s3 <= mem_top[addr_tl];
			pix_tr_s3 <= mem_top[addr_tr];
		end
	end

	// bottom copy
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_bot[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			pix_bl_s3 <= mem_bot[addr_bl];
			pix_br_s3 <= mem_bot[addr_br];
		end
	end

endmodule

### hdl/bsr_blend.sv
// ----------------------------------------------------------------------------
// bsr_blend
// Weighting stages 3 to 5: corner weights, per-channel products, rounded
// sum and the registered result.
// ----------------------------------------------------------------------------
module bsr_blend
	import bsr_pkg::*;
#(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	localparam int PIX_BITS    = 3 * CHANNEL_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pipe_ctrl_t           ctrl_s2,
	input  logic [FRAC_BITS-1:0] fx_s2,
	input  logic [FRAC_BITS-1:0] fy_s2,
	input  logic [PIX_BITS-1:0]  pix_tl_s3,
	input  logic [PIX_BITS-1:0]  pix_tr_s3,
	input  logic [PIX_BITS-1:0]  pix_bl_s3,
	input  logic [PIX_BITS-1:0]  pix_br_s3,
	output logic                 result_strobe,
	output out_item_t            result
);

	localparam int W_BITS = 2 * FRAC_BITS + 1;
	localparam int P_BITS = CHANNEL_BITS + W_BITS;
	localparam int S_BITS = P_BITS + 2;
	localparam logic [FRAC_BITS:0] ONE_FIX   = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [S_BITS-1:0]  ROUND_ADD = S_BITS'(1) << (2 * FRAC_BITS - 1);

	logic [FRAC_BITS:0]  nfx, nfy, fx_ext, fy_ext;
	logic [PIX_BITS-1:0] pix_c [4];

	logic                valid_s3, oor_s3;
	logic [W_BITS-1:0]   w_s3 [4];
	logic                valid_s4, oor_s4;
	logic [P_BITS-1:0]   prod_s4 [3][4];
	logic [S_BITS-1:0]   sum_c [3];
	logic                result_strobe_s5;
	out_item_t           result_s5;

	// corner order: top-left, bottom-left, top-right, bottom-right
	assign pix_c[0] = pix_tl_s3;
	assign pix_c[1] = pix_bl_s3;
	assign pix_c[2] = pix_tr_s3;
	assign pix_c[3] = pix_br_s3;

	assign fx_ext = {1'b0, fx_s2};
	assign fy_ext = {1'b0, fy_s2};
	assign nfx    = ONE_FIX - fx_ext;
	assign nfy    = ONE_FIX - fy_ext;

	// stage 3: weights, lined up with the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= ctrl_s2.valid && ctrl_s2.sample;
		end
	end

	always_ff @(posedge clk) begin
		oor_s3  <= ctrl_s2.oor;
		w_s3[0] <= W_BITS'(nfx) * W_BITS'(nfy);
		w_s3[1] <= W_BITS'(nfx) * W_BITS'(fy_ext);
		w_s3[2] <= W_BITS'(fx_ext) * W_BITS'(nfy);
		w_s3[3] <= W_BITS'(fx_ext) * W_BITS'(fy_ext);
	end

	// stage 4: pixel times weight, channel 0 is red in the top bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		oor_s4 <= oor_s3;
	end

	for (genvar k = 0; k < 3; k++) begin : g_chan
		for (genvar c = 0; c < 4; c++) begin : g_corner
			always_ff @(posedge clk) begin
				prod_s4[k][c] <= P_BITS'(pix_c[c][(2 - k) * CHANNEL_BITS +: CHANNEL_BITS]) *
					P_BITS'(w_s3[c]);
			end
		end
		// rounded sum, halves up
		assign sum_c[k] = S_BITS'(prod_s4[k][0]) + S_BITS'(prod_s4[k][1]) +
			S_BITS'(prod_s4[k][2]) + S_BITS'(prod_s4[k][3]) + ROUND_ADD;
	end

	// stage 5: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe_s5 <= 1'b0;
		end else begin
			result_strobe_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (oor_s4) begin
			result_s5.red_out   <= '0;
			result_s5.green_out <= '0;
			result_s5.blue_out  <= '0;
		end else begin
			result_s5.red_out   <= sum_c[0][2 * FRAC_BITS +: OUT_CH_BITS];
			result_s5.green_out <= sum_c[1][2 * FRAC_BITS +: OUT_CH_BITS];
			result_s5.blue_out  <= sum_c[2][2 * FRAC_BITS +: OUT_CH_BITS];
		end
		result_s5.out_of_range <= oor_s4;
	end

	assign result_strobe = result_strobe_s5;
	assign result        = result_s5;

endmodule

### hdl/bilinear_sample_rgb.sv
// A sample's result strobe is driven by the stage 5 result register.
// Throughput: one item per cycle; busy is always low, the 2x2 read uses two store copies.
// A pixel write reaches the store from stage 2 registers; a sample accepted next sees it.
// Reset clears all pipeline valid bits and sets image_width and image_height to 256.
// The pixel store is not cleared by reset; a pixel is defined once written.
// The receiver cannot stall: each result stands for exactly one cycle.
// ----------------------------------------------------------------------------
// bilinear_sample_rgb
// Bilinear RGB sampler: pixel writes and Q-format samples over a 2x2
// neighbourhood, five-stage pipeline with a duplicated pixel store.
// ----------------------------------------------------------------------------
module bilinear_sample_rgb
	import bsr_pkg::*;
#(
	parameter int MAX_PIXELS   = MAX_PIXELS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  in_item_t            item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	output logic                result_strobe,
	output out_item_t           result
);

	localparam int ADDR_BITS = $clog2(MAX_PIXELS);
	localparam int PIX_BITS  = 3 * CHANNEL_BITS;

	logic [CFG_BITS-1:0]  image_width_q, image_height_q;
	logic                 accept;
	pipe_ctrl_t           ctrl_s2;
	logic [ADDR_BITS-1:0] addr_tl_s2, addr_tr_s2, addr_bl_s2, addr_br_s2;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2;
	logic [PIX_BITS-1:0]  pix_s2;
	logic [PIX_BITS-1:0]  pix_tl_s3, pix_tr_s3, pix_bl_s3, pix_br_s3;

	// never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default:          image_width_q  <= image_width_q;
			endcase
		end
	end

	// address stages
	bsr_addr #(
		.MAX_PIXELS   (MAX_PIXELS),
		.FRAC_BITS    (FRAC_BITS),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.ctrl_s2      (ctrl_s2),
		.addr_tl_s2   (addr_tl_s2),
		.addr_tr_s2   (addr_tr_s2),
		.addr_bl_s2   (addr_bl_s2),
		.addr_br_s2   (addr_br_s2),
		.fx_s2        (fx_s2),
		.fy_s2        (fy_s2),
		.pix_s2       (pix_s2)
	);

	// pixel store
	bsr_mem #(
		.MAX_PIXELS   (MAX_PIXELS),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_mem (
		.clk       (clk),
		.wr_en     (ctrl_s2.wr),
		.wr_addr   (addr_tl_s2),
		.wr_data   (pix_s2),
		.rd_en     (ctrl_s2.sample && !ctrl_s2.oor),
		.addr_tl   (addr_tl_s2),
		.addr_tr   (addr_tr_s2),
		.addr_bl   (addr_bl_s2),
		.addr_br   (addr_br_s2),
		.pix_tl_s3 (pix_tl_s3),
		.pix_tr_s3 (pix_tr_s3),
		.pix_bl_s3 (pix_bl_s3),
		.pix_br_s3 (pix_br_s3)
	);

	// weighting stages
	bsr_blend #(
		.FRAC_BITS    (FRAC_BITS),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl_s2       (ctrl_s2),
		.fx_s2         (fx_s2),
		.fy_s2         (fy_s2),
		.pix_tl_s3     (pix_tl_s3),
		.pix_tr_s3     (pix_tr_s3),
		.pix_bl_s3     (pix_bl_s3),
		.pix_br_s3     (pix_br_s3),
		.result_strobe (result_strobe),
		.result        (result)
	);

`ifndef SYNTHESIS
	// every sample transfer is followed by a result strobe
	a_sample_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.cmd == CMD_SAMPLE)) |-> ##5 result_strobe)
		else $error("sample transfer gave no result");

	// a pixel write gives no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.cmd == CMD_WRITE)) |-> ##5 !result_strobe)
		else $error("pixel write gave a result");

	// out-of-range results carry zero channels
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.out_of_range) |->
		((result.red_out == '0) && (result.green_out == '0) && (result.blue_out == '0)))
		else $error("out-of-range result with nonzero channels");
`endif

endmodule
